/* hw/rtl/mmx_pkg.sv */
// Shared constants and types of the 4x4 fixed-point matrix multiplier.
`default_nettype none

package mmx_pkg;

   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;
   localparam int CELLS     = DIM * DIM;

   localparam int POS_W  = 4;
   localparam int DATA_W = 32;
   localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = PROD_W + IDX_W;
   localparam int RND_W  = ACC_W + 1;

   typedef struct packed {
      logic mul;     // register the product of the current operand pair
      logic add;     // add the registered product into the accumulator
      logic first;   // first term of an element: start the sum from zero
      logic fin;     // round, shift and clip the sum into the result register
   } mac_ctrl_type;

endpackage

`default_nettype wire

/* hw/rtl/mmx_if.sv */
// Valid/ready channel interfaces for load items and product elements.
`default_nettype none

interface mmx_req_if;
   logic                                valid;
   logic                                ready;
   logic        [mmx_pkg::POS_W-1:0]    position;
   logic signed [mmx_pkg::DATA_W-1:0]   left_value;
   logic signed [mmx_pkg::DATA_W-1:0]   right_value;
   logic                                final_load;

   modport source (output valid, position, left_value, right_value, final_load,
                   input ready);
   modport sink   (input valid, position, left_value, right_value, final_load,
                   output ready);
endinterface

interface mmx_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [mmx_pkg::POS_W-1:0]    out_position;
   logic signed [mmx_pkg::DATA_W-1:0]   product_value;
   logic                                saturated;
   logic                                end_of_matrix;

   modport source (output valid, out_position, product_value, saturated, end_of_matrix,
                   input ready);
   modport sink   (input valid, out_position, product_value, saturated, end_of_matrix,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/mmx_store.sv */
// Left and right element stores with per-entry valid bits; unloaded entries read zero.
`default_nettype none

module mmx_store (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_en,
   input  wire logic        [mmx_pkg::POS_W-1:0]    wr_pos,
   input  wire logic signed [mmx_pkg::DATA_W-1:0]   wr_left,
   input  wire logic signed [mmx_pkg::DATA_W-1:0]   wr_right,
   input  wire logic                                clear,
   input  wire logic        [mmx_pkg::POS_W-1:0]    rd_left_pos,
   input  wire logic        [mmx_pkg::POS_W-1:0]    rd_right_pos,
   output logic signed      [mmx_pkg::DATA_W-1:0]   rd_left,
   output logic signed      [mmx_pkg::DATA_W-1:0]   rd_right
);

   logic signed [mmx_pkg::DATA_W-1:0] left_ff  [mmx_pkg::CELLS];
   logic signed [mmx_pkg::DATA_W-1:0] right_ff [mmx_pkg::CELLS];
   logic        [mmx_pkg::CELLS-1:0]  valid_ff;
   logic        [mmx_pkg::CELLS-1:0]  valid_in;
   logic                              wr_hit;

   // positions at or beyond the matrix size store nothing
   assign wr_hit = wr_en && (int'(wr_pos) < mmx_pkg::CELLS);

   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_hit) begin
         valid_in[wr_pos] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         left_ff[wr_pos]  <= wr_left;
         right_ff[wr_pos] <= wr_right;
      end
   end

   always_comb begin
      rd_left  = '0;
      rd_right = '0;
      if ((int'(rd_left_pos) < mmx_pkg::CELLS) && valid_ff[rd_left_pos]) begin
         rd_left = left_ff[rd_left_pos];
      end
      if ((int'(rd_right_pos) < mmx_pkg::CELLS) && valid_ff[rd_right_pos]) begin
         rd_right = right_ff[rd_right_pos];
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/mmx_mac.sv */
// Shared multiply-accumulate unit with round-to-nearest and 32-bit saturation.
`default_nettype none

module mmx_mac (
   input  wire logic                                clock,
   input  wire mmx_pkg::mac_ctrl_type               ctrl,
   input  wire logic signed [mmx_pkg::DATA_W-1:0]   op_a,
   input  wire logic signed [mmx_pkg::DATA_W-1:0]   op_b,
   output logic signed      [mmx_pkg::DATA_W-1:0]   result,
   output logic                                     result_sat
);

   localparam logic signed [mmx_pkg::RND_W-1:0] ROUND_HALF =
      (mmx_pkg::FRAC_BITS > 0) ? (mmx_pkg::RND_W'(1) << (mmx_pkg::FRAC_BITS - 1)) : '0;
   localparam int SIGN_W = mmx_pkg::RND_W - mmx_pkg::DATA_W + 1;

   logic signed [mmx_pkg::PROD_W-1:0] prod_ff;
   logic signed [mmx_pkg::PROD_W-1:0] prod_in;
   logic signed [mmx_pkg::ACC_W-1:0]  acc_ff;
   logic signed [mmx_pkg::ACC_W-1:0]  acc_in;
   logic signed [mmx_pkg::DATA_W-1:0] result_ff;
   logic signed [mmx_pkg::DATA_W-1:0] result_in;
   logic                              sat_ff;
   logic                              sat_in;
   logic signed [mmx_pkg::RND_W-1:0]  rounded;
   logic signed [mmx_pkg::RND_W-1:0]  shifted;
   logic        [SIGN_W-1:0]          top_bits;
   logic                              fits;

   assign prod_in = op_a * op_b;
   assign acc_in  = (ctrl.first ? '0 : acc_ff) + mmx_pkg::ACC_W'(prod_ff);

   // ties round toward plus infinity, then arithmetic shift
   assign rounded  = mmx_pkg::RND_W'(acc_ff) + ROUND_HALF;
   assign shifted  = rounded >>> mmx_pkg::FRAC_BITS;
   assign top_bits = shifted[mmx_pkg::RND_W-1:mmx_pkg::DATA_W-1];
   assign fits     = (&top_bits) || !(|top_bits);

   always_comb begin
      sat_in    = !fits;
      result_in = shifted[mmx_pkg::DATA_W-1:0];
      if (!fits) begin
         result_in = shifted[mmx_pkg::RND_W-1]
                   ? {1'b1, {(mmx_pkg::DATA_W-1){1'b0}}}
                   : {1'b0, {(mmx_pkg::DATA_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul) begin
         prod_ff <= prod_in;
      end
      if (ctrl.add) begin
         acc_ff <= acc_in;
      end
      if (ctrl.fin) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result     = result_ff;
   assign result_sat = sat_ff;

endmodule

`default_nettype wire

/* hw/rtl/matrix4x4_multiply.sv */
// Top level: load sequencing, product sequencer and result channel of the matrix multiplier.
//
// Each load item is taken while the block is idle and writes one element of the
// left and right matrices (signed Q16.16); positions never loaded read as zero. An
// item with final_load set starts the product: the block drops ready and computes
// the 16 elements in row-major order with a single shared 32x32 multiplier and a
// 66-bit accumulator, one multiply and one add per term. Each element is held on
// the result channel until the sink takes it, and only then does the next element
// start. Sums are rounded to nearest (ties up) and clipped to 32 bits with the
// saturated flag set. Both stores are emptied after the sixteenth element, which
// carries end_of_matrix, and ready returns in the next cycle.
`default_nettype none

module matrix4x4_multiply (
   input  wire logic clock,
   input  wire logic reset,
   mmx_req_if.sink   req_chan,
   mmx_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_ROUND,
      ST_SEND
   } state_type;

   state_type                          state_ff;
   logic        [mmx_pkg::IDX_W-1:0]   row_ff;
   logic        [mmx_pkg::IDX_W-1:0]   col_ff;
   logic        [mmx_pkg::IDX_W-1:0]   k_ff;
   logic        [mmx_pkg::POS_W-1:0]   out_pos_ff;
   logic                               end_ff;

   logic                               req_xfer;
   logic                               rsp_xfer;
   logic                               last_term;
   logic                               last_elem;
   logic        [mmx_pkg::POS_W-1:0]   left_pos;
   logic        [mmx_pkg::POS_W-1:0]   right_pos;
   logic        [mmx_pkg::POS_W-1:0]   elem_pos;
   logic signed [mmx_pkg::DATA_W-1:0]  left_elem;
   logic signed [mmx_pkg::DATA_W-1:0]  right_elem;
   logic signed [mmx_pkg::DATA_W-1:0]  mac_result;
   logic                               mac_sat;
   mmx_pkg::mac_ctrl_type              mac_ctrl;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = (state_ff == ST_SEND);
   assign rsp_xfer       = rsp_chan.valid && rsp_chan.ready;

   assign last_term = (k_ff == mmx_pkg::IDX_W'(mmx_pkg::DIM - 1));
   assign last_elem = (row_ff == mmx_pkg::IDX_W'(mmx_pkg::DIM - 1))
                   && (col_ff == mmx_pkg::IDX_W'(mmx_pkg::DIM - 1));

   // A[row][k] and B[k][col]
   assign left_pos  = mmx_pkg::POS_W'(int'(row_ff) * mmx_pkg::DIM + int'(k_ff));
   assign right_pos = mmx_pkg::POS_W'(int'(k_ff) * mmx_pkg::DIM + int'(col_ff));
   assign elem_pos  = mmx_pkg::POS_W'(int'(row_ff) * mmx_pkg::DIM + int'(col_ff));

   always_comb begin
      mac_ctrl       = '0;
      mac_ctrl.mul   = (state_ff == ST_MUL);
      mac_ctrl.add   = (state_ff == ST_ADD);
      mac_ctrl.first = (k_ff == '0);
      mac_ctrl.fin   = (state_ff == ST_ROUND);
   end

   mmx_store u_store (
      .clock        (clock),
      .reset        (reset),
      .wr_en        (req_xfer),
      .wr_pos       (req_chan.position),
      .wr_left      (req_chan.left_value),
      .wr_right     (req_chan.right_value),
      .clear        (rsp_xfer && last_elem),
      .rd_left_pos  (left_pos),
      .rd_right_pos (right_pos),
      .rd_left      (left_elem),
      .rd_right     (right_elem)
   );

   mmx_mac u_mac (
      .clock      (clock),
      .ctrl       (mac_ctrl),
      .op_a       (left_elem),
      .op_b       (right_elem),
      .result     (mac_result),
      .result_sat (mac_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         row_ff     <= '0;
         col_ff     <= '0;
         k_ff       <= '0;
         out_pos_ff <= '0;
         end_ff     <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer && req_chan.final_load) begin
                  row_ff   <= '0;
                  col_ff   <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               if (last_term) begin
                  state_ff <= ST_ROUND;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_ROUND: begin
               out_pos_ff <= elem_pos;
               end_ff     <= last_elem;
               state_ff   <= ST_SEND;
            end
            ST_SEND: begin
               if (rsp_xfer) begin
                  k_ff <= '0;
                  if (last_elem) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     if (col_ff == mmx_pkg::IDX_W'(mmx_pkg::DIM - 1)) begin
                        col_ff <= '0;
                        row_ff <= row_ff + 1'b1;
                     end else begin
                        col_ff <= col_ff + 1'b1;
                     end
                     state_ff <= ST_MUL;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.out_position  = out_pos_ff;
   assign rsp_chan.product_value = mac_result;
   assign rsp_chan.saturated     = mac_sat;
   assign rsp_chan.end_of_matrix = end_ff;

   // no load is taken while an element is on offer
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("load accepted while a product element is pending");

   // a final load starts the product at element zero, term zero
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_chan.final_load) |=>
         (state_ff == ST_MUL) && (row_ff == '0) && (col_ff == '0) && (k_ff == '0))
      else $error("product did not start at the first element");

   // the marked element is the last one, and the block is free right after it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_chan.end_of_matrix) |=> req_chan.ready && !rsp_chan.valid)
      else $error("block not idle after the last element");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.end_of_matrix == (rsp_chan.out_position ==
                                     mmx_pkg::POS_W'(mmx_pkg::CELLS - 1))))
      else $error("end marker does not match the last position");

endmodule

`default_nettype wire
